// ===== design/rrqb_pkg.sv =====
// ----------------------------------------------------------------------------
// rrqb_pkg: shared types and codes of the ready queue
// Request codes, status codes and the packed item structs of both channels.
// ----------------------------------------------------------------------------
package rrqb_pkg;

  typedef enum logic [1:0] {
    REQ_PUSH_LAST  = 2'd0,
    REQ_PUSH_FIRST = 2'd1,
    REQ_POP_HEAD   = 2'd2,
    REQ_REMOVE     = 2'd3
  } req_e;

  localparam logic STATUS_DONE   = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  typedef struct packed {
    req_e       req_type;
    logic [4:0] task_id;
    logic [5:0] priority_req;
  } in_item_t;

  typedef struct packed {
    logic       status;
    logic       level_nonempty;
    logic [4:0] level_head;
    logic [7:0] group_word;
    logic [7:0] cluster_word;
  } out_item_t;

endpackage

// ===== design/rrqb_ram.sv =====
// ----------------------------------------------------------------------------
// rrqb_ram: simple dual-port table
// One write port with a write enable per half of the word, one read port with
// a registered read data output.
// ----------------------------------------------------------------------------
module rrqb_ram #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned WIDTH = 12,
  parameter int unsigned AW    = 5
) (
  input  logic             clk_i,
  input  logic [1:0]       we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int unsigned HW = WIDTH / 2;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write the upper and lower halves independently
  always_ff @(posedge clk_i) begin
    if (we_i[1]) begin
      mem_q[waddr_i][WIDTH-1:HW] <= wdata_i[WIDTH-1:HW];
    end
    if (we_i[0]) begin
      mem_q[waddr_i][HW-1:0] <= wdata_i[HW-1:0];
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/rtos_ready_queue_bitmap.sv =====
// ----------------------------------------------------------------------------
// rtos_ready_queue_bitmap: priority ready queue with a two-level bitmap
// One doubly linked list of task ids per priority level, held in a head/tail
// table per level and a next/previous link table per task, plus ready bits
// per level from which the group and cluster words are formed.
// ----------------------------------------------------------------------------
//
//  channel | signals                              | item
//  --------+--------------------------------------+---------------------------
//  in      | in_valid_i / in_ready_o / in_item_i  | request (type, task, level)
//  out     | out_valid_o / out_ready_i / out_item_o | result of one request
//
//  Sequence: one item at a time. A push or remove steps through WR_A and
//  WR_B, a pop through FETCH, WR_A and WR_B, and the result is registered
//  at the end of WR_B: the tables answer in the cycle after the read, a pop
//  reads the old head's next link once more in FETCH, and WR_B stitches the
//  neighbouring link entry through the single link write port. The next
//  item is taken in IDLE, once WR_B has handed its result on.
//  Reset: control state and the per-level ready and row valid bits clear at
//  once; a head/tail row never written reads as empty, so no clearing pass.
//  Stalls: a finished result waits in the output register while the next
//  item is taken in; the final write cycle holds until that register is free.
//
module rtos_ready_queue_bitmap #(
  parameter int unsigned NUM_LEVELS       = 64,
  parameter int unsigned NUM_TASKS        = 32,
  parameter int unsigned LEVELS_PER_GROUP = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  rrqb_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output rrqb_pkg::out_item_t  out_item_o
);

  localparam int unsigned TW = $clog2(NUM_TASKS);   // task id bits
  localparam int unsigned EW = TW + 1;              // entry: empty flag + id
  localparam int unsigned LW = $clog2(NUM_LEVELS);
  localparam int unsigned NG = (NUM_LEVELS + LEVELS_PER_GROUP - 1) / LEVELS_PER_GROUP;
  localparam int unsigned GW = (NG > 1) ? $clog2(NG) : 1;
  localparam logic [EW-1:0] EMPTY_ENT = {1'b1, {TW{1'b0}}};

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_FETCH = 4'b0010,
    ST_WR_A  = 4'b0100,
    ST_WR_B  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // request registers
  rrqb_pkg::req_e req_q;
  logic [TW-1:0]  ti_q;
  logic [LW-1:0]  lvl_q;
  logic           row_ok_q;

  logic [NUM_LEVELS-1:0] level_ready_q, level_ready_d;
  logic [NUM_LEVELS-1:0] row_valid_q, row_valid_d;

  logic                 out_valid_q, out_valid_d;
  rrqb_pkg::out_item_t  out_item_q, out_item_d;

  logic          accept;
  logic [TW-1:0] ti_in;
  logic [LW-1:0] lvl_in;

  // constant lookup tables: wrap ids and levels, find a level's group
  function automatic logic [TW-1:0] wrap_task(logic [4:0] id);
    logic [TW-1:0] r;
    r = '0;
    for (int i = 0; i < 32; i++) begin
      if (id == 5'(i)) begin
        r = TW'(i % NUM_TASKS);
      end
    end
    return r;
  endfunction

  function automatic logic [LW-1:0] wrap_level(logic [5:0] prio);
    logic [LW-1:0] r;
    r = '0;
    for (int i = 0; i < 64; i++) begin
      if (prio == 6'(i)) begin
        r = LW'(i % NUM_LEVELS);
      end
    end
    return r;
  endfunction

  function automatic logic [GW-1:0] group_of(logic [LW-1:0] lvl);
    logic [GW-1:0] g;
    g = '0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (lvl == LW'(i)) begin
        g = GW'(i / LEVELS_PER_GROUP);
      end
    end
    return g;
  endfunction

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  // out-of-range ids and levels wrap
  assign ti_in  = wrap_task(in_item_i.task_id);
  assign lvl_in = wrap_level(in_item_i.priority_req);

  // --------------------------------------------------------------------------
  // Tables
  // --------------------------------------------------------------------------
  logic [2*EW-1:0] row_rdata, row_wdata;
  logic            row_we;
  logic [2*EW-1:0] link_rdata, link_wdata;
  logic [1:0]      link_we;
  logic            link_re;
  logic [TW-1:0]   link_raddr, link_waddr;
  logic [EW-1:0]   next_rdata, prev_rdata;

  rrqb_ram #(
    .DEPTH (NUM_LEVELS),
    .WIDTH (2*EW),
    .AW    (LW)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    ({row_we, row_we}),
    .waddr_i (lvl_q),
    .wdata_i (row_wdata),
    .re_i    (accept),
    .raddr_i (lvl_in),
    .rdata_o (row_rdata)
  );

  // link entry: next link in the upper half, previous link in the lower
  rrqb_ram #(
    .DEPTH (NUM_TASKS),
    .WIDTH (2*EW),
    .AW    (TW)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .re_i    (link_re),
    .raddr_i (link_raddr),
    .rdata_o (link_rdata)
  );

  assign next_rdata = link_rdata[2*EW-1:EW];
  assign prev_rdata = link_rdata[EW-1:0];

  // --------------------------------------------------------------------------
  // Decode what was read
  // --------------------------------------------------------------------------
  logic [EW-1:0] hd, tl, t_ent, new_hd, new_tl;
  logic is_push, front, is_pop, is_rem;
  logic h_emp, pop_go, pop_last, head_hit, tail_hit;

  // a row never written reads as an empty level
  assign hd    = row_ok_q ? row_rdata[2*EW-1:EW] : EMPTY_ENT;
  assign tl    = row_ok_q ? row_rdata[EW-1:0]    : EMPTY_ENT;
  assign t_ent = {1'b0, ti_q};

  assign is_push  = (req_q == rrqb_pkg::REQ_PUSH_LAST) || (req_q == rrqb_pkg::REQ_PUSH_FIRST);
  assign front    = (req_q == rrqb_pkg::REQ_PUSH_FIRST);
  assign is_pop   = (req_q == rrqb_pkg::REQ_POP_HEAD);
  assign is_rem   = (req_q == rrqb_pkg::REQ_REMOVE);
  assign h_emp    = hd[TW];
  // for pop the next link read is that of the old head, otherwise of the task
  assign pop_go   = is_pop && !h_emp;
  assign pop_last = pop_go && next_rdata[TW];
  assign head_hit = !h_emp && (hd[TW-1:0] == ti_q);
  assign tail_hit = !tl[TW] && (tl[TW-1:0] == ti_q);

  always_comb begin
    new_hd = hd;
    new_tl = tl;
    if (is_push) begin
      if (h_emp) begin
        new_hd = t_ent;
        new_tl = t_ent;
      end else if (front) begin
        new_hd = t_ent;
      end else begin
        new_tl = t_ent;
      end
    end else if (is_pop) begin
      if (pop_last) begin
        new_hd = EMPTY_ENT;
        new_tl = EMPTY_ENT;
      end else if (pop_go) begin
        new_hd = next_rdata;
      end
    end else begin
      if (head_hit) begin
        new_hd = next_rdata;
      end
      if (tail_hit) begin
        new_tl = prev_rdata;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Link writes: slot A in ST_WR_A, slot B in ST_WR_B; each
  // slot writes one entry, with a lane enable per half
  // --------------------------------------------------------------------------
  logic          pa_en, na_en, pb_en, nb_en;
  logic [TW-1:0] a_addr, b_addr;
  logic [EW-1:0] pa_data, na_data, nb_data;

  always_comb begin
    pa_en   = 1'b0;
    na_en   = 1'b0;
    a_addr  = ti_q;
    pa_data = EMPTY_ENT;
    na_data = EMPTY_ENT;
    pb_en   = 1'b0;
    nb_en   = 1'b0;
    b_addr  = ti_q;
    nb_data = t_ent;
    if (is_push) begin
      pa_en   = 1'b1;
      pa_data = (h_emp || front) ? EMPTY_ENT : tl;
      na_en   = 1'b1;
      na_data = (!h_emp && front) ? hd : EMPTY_ENT;
      // stitch the old head (push first) or old tail (push last)
      pb_en   = !h_emp && front;
      nb_en   = !h_emp && !front && !tl[TW];
      b_addr  = front ? hd[TW-1:0] : tl[TW-1:0];
    end else if (is_pop) begin
      // the new head loses its previous link
      pa_en   = pop_go && !next_rdata[TW];
      a_addr  = next_rdata[TW-1:0];
    end else if (is_rem) begin
      pa_en   = !next_rdata[TW];
      a_addr  = next_rdata[TW-1:0];
      pa_data = prev_rdata;
      nb_en   = !prev_rdata[TW];
      b_addr  = prev_rdata[TW-1:0];
      nb_data = next_rdata;
    end
  end

  always_comb begin
    link_we = 2'b00;
    if (state_q == ST_WR_A) begin
      link_we = {na_en, pa_en};
    end else if (state_q == ST_WR_B) begin
      link_we = {nb_en, pb_en};
    end
  end

  assign link_waddr = (state_q == ST_WR_B) ? b_addr : a_addr;
  assign link_wdata = (state_q == ST_WR_B) ? {nb_data, t_ent} : {na_data, pa_data};

  // the pop reads the old head's next link in FETCH, once the row has arrived
  assign link_re    = accept || (state_q == ST_FETCH);
  assign link_raddr = (state_q == ST_FETCH) ? hd[TW-1:0] : ti_in;

  assign row_we    = (state_q == ST_WR_A);
  assign row_wdata = {new_hd, new_tl};

  // --------------------------------------------------------------------------
  // Ready bitmap
  // --------------------------------------------------------------------------
  logic ready_set, ready_clr;

  assign ready_set = is_push && h_emp;
  assign ready_clr = pop_last || (is_rem && new_hd[TW]);

  always_comb begin
    level_ready_d = level_ready_q;
    row_valid_d   = row_valid_q;
    if (state_q == ST_WR_A) begin
      row_valid_d[lvl_q] = 1'b1;
      if (ready_set) begin
        level_ready_d[lvl_q] = 1'b1;
      end else if (ready_clr) begin
        level_ready_d[lvl_q] = 1'b0;
      end
    end
  end

  logic [LEVELS_PER_GROUP-1:0] grp_words [NG];
  logic [NG-1:0]               cluster;
  logic [GW-1:0]               grp_sel;

  for (genvar g = 0; g < NG; g++) begin : g_grp
    for (genvar b = 0; b < LEVELS_PER_GROUP; b++) begin : g_bit
      if (g * LEVELS_PER_GROUP + b < NUM_LEVELS) begin : g_real
        assign grp_words[g][b] = level_ready_q[g * LEVELS_PER_GROUP + b];
      end else begin : g_pad
        assign grp_words[g][b] = 1'b0;
      end
    end
    assign cluster[g] = |grp_words[g];
  end

  assign grp_sel = group_of(lvl_q);

  // --------------------------------------------------------------------------
  // Result
  // --------------------------------------------------------------------------
  logic out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    out_item_d.status         = (is_pop && h_emp) ? rrqb_pkg::STATUS_REJECT
                                                  : rrqb_pkg::STATUS_DONE;
    out_item_d.level_nonempty = !new_hd[TW];
    out_item_d.level_head     = new_hd[TW] ? 5'd0 : 5'(new_hd[TW-1:0]);
    out_item_d.group_word     = 8'(grp_words[grp_sel]);
    out_item_d.cluster_word   = 8'(cluster);
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if ((state_q == ST_WR_B) && out_free) begin
      out_valid_d = 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (in_item_i.req_type == rrqb_pkg::REQ_POP_HEAD) ? ST_FETCH : ST_WR_A;
        end
      end
      ST_FETCH: begin
        state_d = ST_WR_A;
      end
      ST_WR_A: begin
        state_d = ST_WR_B;
      end
      ST_WR_B: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      out_valid_q   <= 1'b0;
      level_ready_q <= '0;
      row_valid_q   <= '0;
    end else begin
      state_q       <= state_d;
      out_valid_q   <= out_valid_d;
      level_ready_q <= level_ready_d;
      row_valid_q   <= row_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q    <= in_item_i.req_type;
      ti_q     <= ti_in;
      lvl_q    <= lvl_in;
      row_ok_q <= row_valid_q[lvl_in];
    end
    if ((state_q == ST_WR_B) && out_free) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== design/rrqb_checker.sv =====
// ----------------------------------------------------------------------------
// rrqb_checker: port-level checks of the ready queue
// Watches the channels of the top level; attached by the bind below.
// ----------------------------------------------------------------------------
module rrqb_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input rrqb_pkg::in_item_t  in_item_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input rrqb_pkg::out_item_t out_item_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  // one request in flight at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while another is in flight");

  // a rejected pop leaves the level empty
  a_reject_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status == rrqb_pkg::STATUS_REJECT)
      |-> !out_item_o.level_nonempty)
    else $error("rejected pop reports a non-empty level");

  // an empty level shows head zero
  a_empty_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.level_nonempty |-> (out_item_o.level_head == 5'd0))
    else $error("empty level with non-zero head");

  // a non-empty level shows a non-zero group word
  a_group_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.level_nonempty |-> (out_item_o.group_word != 8'd0))
    else $error("non-empty level with clear group word");

endmodule

bind rtos_ready_queue_bitmap rrqb_checker u_rrqb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);
